/* sv/scord_pkg.sv */
// Shared types for the scan chain ordering core.
// Holds controller states, command/status structs and register indexes.
package scord_pkg;

    typedef enum logic [1:0] {
        REG_START_X = 2'd0,
        REG_START_Y = 2'd1,
        REG_END_X   = 2'd2,
        REG_END_Y   = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        OW_BEST,
        OW_SA,
        OW_SB
    } ord_src_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_NN_INIT,
        S_NN_ROUND,
        S_NN_CHK,
        S_NN_L1,
        S_NN_L2,
        S_NN_TRY,
        S_NN_PICK,
        S_EV_START,
        S_EV_ORD,
        S_EV_COORD,
        S_EV_L1,
        S_EV_L2,
        S_EV_ADD,
        S_EV_END1,
        S_EV_END2,
        S_EV_END3,
        S_EV_DONE,
        S_PASS,
        S_NEXT,
        S_SW_CHK,
        S_SW_RA,
        S_SW_RB,
        S_SW_WA,
        S_SW_WB,
        S_EMIT_RD,
        S_EMIT_OUT
    } state_t;

    typedef struct packed {
        logic     load;        // write loaded word into coordinate store
        logic     coord_rd;    // read coordinate store
        logic     caddr_ord;   // coordinate address from order read data
        logic     ord_rd;
        logic     ord_we;
        ord_src_t ord_src;
        logic     save_sa;
        logic     save_sb;
        logic     used_clr;
        logic     used_set;
        logic     prev_start;
        logic     prev_mem;
        logic     prev_best;
        logic     b_end;       // far point of leg is the exit point
        logic     leg_s1;
        logic     leg_s2;
        logic     tot_clr;
        logic     tot_add;
        logic     best_clr;
        logic     best_try;
        logic     cur_load;
    } dp_cmd_t;

    typedef struct packed {
        logic used_hit;
        logic tot_lt_cur;
    } dp_status_t;

endpackage

/* sv/scan_chain_order_nn_2opt_core.sv */
// Top level of the scan chain ordering core (nearest neighbor plus 2-opt).
// Depends on scord_pkg, scord_ctrl and scord_datapath.
//
//  channel   handshake                 payload
//  input     start, busy               x_coord, y_coord, last_cell
//  result    result_valid (strobe)     cell_index, last_in_path
//  config    cfg_we                    cfg_index, cfg_wdata
//
// A cell word without last_cell is taken while busy is low. A word with last_cell
// holds busy through ordering: in each step the greedy walk visits S_NN_CHK,
// S_NN_L1, S_NN_L2 and S_NN_TRY for a free candidate and only S_NN_CHK for a
// used one, and each 2-opt candidate is rescored over the whole path; the leg
// unit is shared and the order store has a single port. Results then go out,
// each read in S_EMIT_RD and shown in S_EMIT_OUT.
// Reset clears the controller and the entry/exit points; the receiver cannot
// stall results.
module scan_chain_order_nn_2opt_core #(
    parameter int MAX_CELLS = 64,
    parameter int COORD_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] x_coord,
    input  logic signed [31:0] y_coord,
    input  logic               last_cell,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic signed [31:0] cfg_wdata,
    output logic               result_valid,
    output logic [5:0]         cell_index,
    output logic               last_in_path
);

    localparam int IW = $clog2(MAX_CELLS);
    localparam int CW = $clog2(MAX_CELLS + 1);

    scord_pkg::dp_cmd_t    cmd;
    scord_pkg::dp_status_t status;
    logic [IW-1:0]         idx_a;
    logic [IW-1:0]         idx_b;
    logic [IW-1:0]         ord_q;

    scord_ctrl #(
        .MAX_CELLS (MAX_CELLS),
        .IW        (IW),
        .CW        (CW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .last_cell    (last_cell),
        .status       (status),
        .busy         (busy),
        .result_valid (result_valid),
        .last_in_path (last_in_path),
        .cmd          (cmd),
        .idx_a        (idx_a),
        .idx_b        (idx_b)
    );

    scord_datapath #(
        .MAX_CELLS  (MAX_CELLS),
        .COORD_BITS (COORD_BITS),
        .IW         (IW)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .idx_a     (idx_a),
        .idx_b     (idx_b),
        .x_coord   (x_coord),
        .y_coord   (y_coord),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .status    (status),
        .ord_q     (ord_q)
    );

    assign cell_index = 6'(ord_q);

endmodule

/* sv/scord_ctrl.sv */
// Sequencer for the ordering core: load, nearest-neighbor walk, 2-opt passes, emit.
// Depends on scord_pkg; drives scord_datapath through dp_cmd_t.
module scord_ctrl #(
    parameter int MAX_CELLS = 64,
    parameter int IW = 6,
    parameter int CW = 7
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  last_cell,
    input  scord_pkg::dp_status_t status,
    output logic                  busy,
    output logic                  result_valid,
    output logic                  last_in_path,
    output scord_pkg::dp_cmd_t    cmd,
    output logic [IW-1:0]         idx_a,
    output logic [IW-1:0]         idx_b
);

    localparam logic [CW-1:0] MAXC = CW'(MAX_CELLS);
    localparam logic [CW-1:0] ONE  = CW'(1);

    scord_pkg::state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] p_reg, p_next;
    logic [CW-1:0] a_reg, a_next;
    logic [CW-1:0] b_reg, b_next;
    logic          init_reg, init_next;
    logic          impr_reg, impr_next;
    logic [CW-1:0] q;

    // candidate position map: positions i..j-1 reversed
    always_comb
    begin
        if (p_reg >= i_reg && p_reg < j_reg)
            q = i_reg + j_reg - ONE - p_reg;
        else
            q = p_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= scord_pkg::S_IDLE;
            count_reg <= '0;
            k_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            p_reg     <= '0;
            a_reg     <= '0;
            b_reg     <= '0;
            init_reg  <= 1'b0;
            impr_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            k_reg     <= k_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            p_reg     <= p_next;
            a_reg     <= a_next;
            b_reg     <= b_next;
            init_reg  <= init_next;
            impr_reg  <= impr_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        k_next       = k_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        p_next       = p_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        init_next    = init_reg;
        impr_next    = impr_reg;
        cmd          = '0;
        idx_a        = '0;
        idx_b        = '0;
        result_valid = 1'b0;
        last_in_path = 1'b0;
        busy         = (state_reg != scord_pkg::S_IDLE);

        unique case (state_reg)
            scord_pkg::S_IDLE:
            begin
                idx_a = count_reg[IW-1:0];
                if (start)
                begin
                    if (count_reg < MAXC)
                    begin
                        cmd.load   = 1'b1;
                        count_next = count_reg + ONE;
                    end
                    if (last_cell)
                        state_next = scord_pkg::S_NN_INIT;
                end
            end
            scord_pkg::S_NN_INIT:
            begin
                cmd.used_clr   = 1'b1;
                cmd.prev_start = 1'b1;
                k_next         = '0;
                state_next     = scord_pkg::S_NN_ROUND;
            end
            scord_pkg::S_NN_ROUND:
            begin
                cmd.best_clr = 1'b1;
                i_next       = '0;
                state_next   = scord_pkg::S_NN_CHK;
            end
            scord_pkg::S_NN_CHK:
            begin
                idx_a = i_reg[IW-1:0];
                if (i_reg == count_reg)
                    state_next = scord_pkg::S_NN_PICK;
                else if (status.used_hit)
                    i_next = i_reg + ONE;
                else
                begin
                    cmd.coord_rd = 1'b1;
                    state_next   = scord_pkg::S_NN_L1;
                end
            end
            scord_pkg::S_NN_L1:
            begin
                cmd.leg_s1 = 1'b1;
                state_next = scord_pkg::S_NN_L2;
            end
            scord_pkg::S_NN_L2:
            begin
                cmd.leg_s2 = 1'b1;
                state_next = scord_pkg::S_NN_TRY;
            end
            scord_pkg::S_NN_TRY:
            begin
                idx_a        = i_reg[IW-1:0];
                cmd.best_try = 1'b1;
                i_next       = i_reg + ONE;
                state_next   = scord_pkg::S_NN_CHK;
            end
            scord_pkg::S_NN_PICK:
            begin
                idx_b         = k_reg[IW-1:0];
                cmd.ord_we    = 1'b1;
                cmd.ord_src   = scord_pkg::OW_BEST;
                cmd.used_set  = 1'b1;
                cmd.prev_best = 1'b1;
                k_next        = k_reg + ONE;
                if (k_reg + ONE == count_reg)
                begin
                    // score the greedy order with an empty reversal
                    init_next  = 1'b1;
                    i_next     = '0;
                    j_next     = '0;
                    state_next = scord_pkg::S_EV_START;
                end
                else
                    state_next = scord_pkg::S_NN_ROUND;
            end
            scord_pkg::S_EV_START:
            begin
                cmd.tot_clr    = 1'b1;
                cmd.prev_start = 1'b1;
                p_next         = '0;
                state_next     = scord_pkg::S_EV_ORD;
            end
            scord_pkg::S_EV_ORD:
            begin
                idx_b = q[IW-1:0];
                if (p_reg == count_reg)
                    state_next = scord_pkg::S_EV_END1;
                else
                begin
                    cmd.ord_rd = 1'b1;
                    state_next = scord_pkg::S_EV_COORD;
                end
            end
            scord_pkg::S_EV_COORD:
            begin
                cmd.coord_rd  = 1'b1;
                cmd.caddr_ord = 1'b1;
                state_next    = scord_pkg::S_EV_L1;
            end
            scord_pkg::S_EV_L1:
            begin
                cmd.leg_s1 = 1'b1;
                state_next = scord_pkg::S_EV_L2;
            end
            scord_pkg::S_EV_L2:
            begin
                cmd.leg_s2 = 1'b1;
                state_next = scord_pkg::S_EV_ADD;
            end
            scord_pkg::S_EV_ADD:
            begin
                cmd.tot_add  = 1'b1;
                cmd.prev_mem = 1'b1;
                p_next       = p_reg + ONE;
                state_next   = scord_pkg::S_EV_ORD;
            end
            scord_pkg::S_EV_END1:
            begin
                cmd.b_end  = 1'b1;
                cmd.leg_s1 = 1'b1;
                state_next = scord_pkg::S_EV_END2;
            end
            scord_pkg::S_EV_END2:
            begin
                cmd.leg_s2 = 1'b1;
                state_next = scord_pkg::S_EV_END3;
            end
            scord_pkg::S_EV_END3:
            begin
                cmd.tot_add = 1'b1;
                state_next  = scord_pkg::S_EV_DONE;
            end
            scord_pkg::S_EV_DONE:
            begin
                if (init_reg)
                begin
                    cmd.cur_load = 1'b1;
                    init_next    = 1'b0;
                    state_next   = scord_pkg::S_PASS;
                end
                else if (status.tot_lt_cur)
                begin
                    cmd.cur_load = 1'b1;
                    impr_next    = 1'b1;
                    a_next       = i_reg;
                    b_next       = j_reg - ONE;
                    state_next   = scord_pkg::S_SW_CHK;
                end
                else
                    state_next = scord_pkg::S_NEXT;
            end
            scord_pkg::S_PASS:
            begin
                impr_next = 1'b0;
                i_next    = '0;
                j_next    = ONE;
                p_next    = '0;
                if (count_reg < CW'(3))
                    state_next = scord_pkg::S_EMIT_RD;
                else
                    state_next = scord_pkg::S_EV_START;
            end
            scord_pkg::S_NEXT:
            begin
                p_next = '0;
                if (j_reg + ONE < count_reg)
                begin
                    j_next     = j_reg + ONE;
                    state_next = scord_pkg::S_EV_START;
                end
                else if (i_reg + CW'(3) < count_reg)
                begin
                    i_next     = i_reg + ONE;
                    j_next     = i_reg + CW'(2);
                    state_next = scord_pkg::S_EV_START;
                end
                else if (impr_reg)
                    state_next = scord_pkg::S_PASS;
                else
                    state_next = scord_pkg::S_EMIT_RD;
            end
            scord_pkg::S_SW_CHK:
            begin
                idx_b = a_reg[IW-1:0];
                if (a_reg < b_reg)
                begin
                    cmd.ord_rd = 1'b1;
                    state_next = scord_pkg::S_SW_RA;
                end
                else
                    state_next = scord_pkg::S_NEXT;
            end
            scord_pkg::S_SW_RA:
            begin
                idx_b       = b_reg[IW-1:0];
                cmd.save_sa = 1'b1;
                cmd.ord_rd  = 1'b1;
                state_next  = scord_pkg::S_SW_RB;
            end
            scord_pkg::S_SW_RB:
            begin
                cmd.save_sb = 1'b1;
                state_next  = scord_pkg::S_SW_WA;
            end
            scord_pkg::S_SW_WA:
            begin
                idx_b       = a_reg[IW-1:0];
                cmd.ord_we  = 1'b1;
                cmd.ord_src = scord_pkg::OW_SB;
                state_next  = scord_pkg::S_SW_WB;
            end
            scord_pkg::S_SW_WB:
            begin
                idx_b       = b_reg[IW-1:0];
                cmd.ord_we  = 1'b1;
                cmd.ord_src = scord_pkg::OW_SA;
                a_next      = a_reg + ONE;
                b_next      = b_reg - ONE;
                state_next  = scord_pkg::S_SW_CHK;
            end
            scord_pkg::S_EMIT_RD:
            begin
                idx_b      = p_reg[IW-1:0];
                cmd.ord_rd = 1'b1;
                state_next = scord_pkg::S_EMIT_OUT;
            end
            scord_pkg::S_EMIT_OUT:
            begin
                result_valid = 1'b1;
                last_in_path = (p_reg + ONE == count_reg);
                p_next       = p_reg + ONE;
                if (p_reg + ONE == count_reg)
                begin
                    count_next = '0;
                    state_next = scord_pkg::S_IDLE;
                end
                else
                    state_next = scord_pkg::S_EMIT_RD;
            end
            default:
                state_next = scord_pkg::S_IDLE;
        endcase
    end

endmodule

/* sv/scord_datapath.sv */
// Datapath of the ordering core: coordinate and order stores, leg unit, totals.
// Depends on scord_pkg; commanded by scord_ctrl.
module scord_datapath #(
    parameter int MAX_CELLS = 64,
    parameter int COORD_BITS = 32,
    parameter int IW = 6
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  scord_pkg::dp_cmd_t    cmd,
    input  logic [IW-1:0]         idx_a,
    input  logic [IW-1:0]         idx_b,
    input  logic signed [31:0]    x_coord,
    input  logic signed [31:0]    y_coord,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic signed [31:0]    cfg_wdata,
    output scord_pkg::dp_status_t status,
    output logic [IW-1:0]         ord_q
);

    localparam int CB = COORD_BITS;

    logic [CB-1:0] xmem [MAX_CELLS];
    logic [CB-1:0] ymem [MAX_CELLS];
    logic [IW-1:0] omem [MAX_CELLS];

    logic [CB-1:0] sx_reg, sy_reg, ex_reg, ey_reg;
    logic [CB-1:0] cx_reg, cy_reg;
    logic [CB-1:0] px_reg, py_reg;
    logic [CB-1:0] bx_reg, by_reg;
    logic [CB-1:0] dx_reg, dy_reg;
    logic [CB:0]   leg_reg;
    logic [CB:0]   bestd_reg;
    logic          found_reg;
    logic [IW-1:0] best_reg;
    logic [IW-1:0] sa_reg, sb_reg;
    logic [63:0]   tot_reg, cur_reg;
    logic [MAX_CELLS-1:0] used_reg;

    logic [CB-1:0] xin, yin, cfg_v;
    logic [CB-1:0] fx, fy;
    logic [IW-1:0] caddr;
    logic [IW-1:0] owdata;
    logic [64:0]   tsum;

    // sign-extend or truncate, then flip the sign bit (offset binary)
    always_comb
    begin
        xin   = CB'(x_coord);
        yin   = CB'(y_coord);
        cfg_v = CB'(cfg_wdata);
        xin[CB-1]   = ~xin[CB-1];
        yin[CB-1]   = ~yin[CB-1];
        cfg_v[CB-1] = ~cfg_v[CB-1];
    end

    assign caddr = cmd.caddr_ord ? ord_q : idx_a;
    assign fx    = cmd.b_end ? ex_reg : cx_reg;
    assign fy    = cmd.b_end ? ey_reg : cy_reg;
    assign tsum  = {1'b0, tot_reg} + 65'(leg_reg);

    always_comb
    begin
        case (cmd.ord_src)
            scord_pkg::OW_SA: owdata = sa_reg;
            scord_pkg::OW_SB: owdata = sb_reg;
            default:          owdata = best_reg;
        endcase
    end

    assign status.used_hit   = used_reg[idx_a];
    assign status.tot_lt_cur = (tot_reg < cur_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            xmem[idx_a] <= xin;
            ymem[idx_a] <= yin;
        end
        if (cmd.coord_rd)
        begin
            cx_reg <= xmem[caddr];
            cy_reg <= ymem[caddr];
        end
        if (cmd.ord_we)
            omem[idx_b] <= owdata;
        if (cmd.ord_rd)
            ord_q <= omem[idx_b];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sx_reg    <= {1'b1, {(CB-1){1'b0}}};
            sy_reg    <= {1'b1, {(CB-1){1'b0}}};
            ex_reg    <= {1'b1, {(CB-1){1'b0}}};
            ey_reg    <= {1'b1, {(CB-1){1'b0}}};
            used_reg  <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (scord_pkg::reg_index_t'(cfg_index))
                    scord_pkg::REG_START_X: sx_reg <= cfg_v;
                    scord_pkg::REG_START_Y: sy_reg <= cfg_v;
                    scord_pkg::REG_END_X:   ex_reg <= cfg_v;
                    scord_pkg::REG_END_Y:   ey_reg <= cfg_v;
                    default: ;
                endcase
            end
            if (cmd.used_clr)
                used_reg <= '0;
            else if (cmd.used_set)
                used_reg[best_reg] <= 1'b1;
            if (cmd.best_clr)
                found_reg <= 1'b0;
            else if (cmd.best_try && (!found_reg || leg_reg < bestd_reg))
                found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.prev_start)
        begin
            px_reg <= sx_reg;
            py_reg <= sy_reg;
        end
        else if (cmd.prev_mem)
        begin
            px_reg <= cx_reg;
            py_reg <= cy_reg;
        end
        else if (cmd.prev_best)
        begin
            px_reg <= bx_reg;
            py_reg <= by_reg;
        end
        if (cmd.leg_s1)
        begin
            dx_reg <= (px_reg > fx) ? px_reg - fx : fx - px_reg;
            dy_reg <= (py_reg > fy) ? py_reg - fy : fy - py_reg;
        end
        if (cmd.leg_s2)
            leg_reg <= {1'b0, dx_reg} + {1'b0, dy_reg};
        if (cmd.best_try && (!found_reg || leg_reg < bestd_reg))
        begin
            best_reg  <= idx_a;
            bestd_reg <= leg_reg;
            bx_reg    <= cx_reg;
            by_reg    <= cy_reg;
        end
        if (cmd.tot_clr)
            tot_reg <= '0;
        else if (cmd.tot_add)
            tot_reg <= tsum[64] ? {64{1'b1}} : tsum[63:0];
        if (cmd.cur_load)
            cur_reg <= tot_reg;
        if (cmd.save_sa)
            sa_reg <= ord_q;
        if (cmd.save_sb)
            sb_reg <= ord_q;
    end

endmodule

/* sim/scord_checker.sv */
// Checker for the scan chain ordering core: watches the cell, config and result ports.
// Predicts each path order (greedy walk, then 2-opt) and compares it result by result.
// Depends on scord_pkg.
`timescale 1ns / 1ps

module scord_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [31:0] x_coord,
    input  logic signed [31:0] y_coord,
    input  logic               last_cell,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic signed [31:0] cfg_wdata,
    input  logic               result_valid,
    input  logic [5:0]         cell_index,
    input  logic               last_in_path,
    output int                 fails,
    output int                 pending,
    output int                 words_checked
);

    localparam int CAP = 64;

    typedef struct {
        logic [5:0] idx;
        logic       last;
    } path_word_t;

    path_word_t  path_q[$];
    logic [63:0] x_mem[CAP];
    logic [63:0] y_mem[CAP];
    int          held;
    int          path[CAP];
    logic [31:0] entry_x, entry_y, exit_x, exit_y;

    function automatic logic [63:0] biased(logic [31:0] v);
        return {32'b0, v ^ 32'h8000_0000};
    endfunction

    function automatic logic [63:0] sum_sat(logic [63:0] a, logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        return (s < a) ? 64'hFFFF_FFFF_FFFF_FFFF : s;
    endfunction

    function automatic logic [63:0] manhattan(logic [63:0] ax, logic [63:0] ay,
                                              logic [63:0] bx, logic [63:0] by);
        logic [63:0] dx, dy;
        dx = (ax > bx) ? ax - bx : bx - ax;
        dy = (ay > by) ? ay - by : by - ay;
        return sum_sat(dx, dy);
    endfunction

    function automatic logic [63:0] route_len(int ord[CAP], int n);
        logic [63:0] total;
        if (n == 0)
            return 0;
        total = manhattan(biased(entry_x), biased(entry_y), x_mem[ord[0]], y_mem[ord[0]]);
        for (int k = 0; k + 1 < n; k++)
            total = sum_sat(total, manhattan(x_mem[ord[k]], y_mem[ord[k]],
                                             x_mem[ord[k+1]], y_mem[ord[k+1]]));
        total = sum_sat(total, manhattan(x_mem[ord[n-1]], y_mem[ord[n-1]],
                                         biased(exit_x), biased(exit_y)));
        return total;
    endfunction

    function automatic void order_cells(int n);
        bit          taken[CAP];
        logic [63:0] cx, cy, bd, d, cur, len;
        int          best, t;
        int          trial[CAP];
        bit          better;
        for (int i = 0; i < CAP; i++)
            taken[i] = 0;
        cx = biased(entry_x);
        cy = biased(entry_y);
        for (int k = 0; k < n; k++) begin
            best = -1;
            bd = 0;
            for (int i = 0; i < n; i++)
                if (!taken[i]) begin
                    d = manhattan(cx, cy, x_mem[i], y_mem[i]);
                    if (best < 0 || d < bd) begin
                        best = i;
                        bd = d;
                    end
                end
            path[k] = best;
            taken[best] = 1;
            cx = x_mem[best];
            cy = y_mem[best];
        end
        cur = route_len(path, n);
        better = 1;
        while (better) begin
            better = 0;
            for (int i = 0; i + 2 < n; i++)
                for (int j = i + 1; j < n; j++) begin
                    trial = path;
                    for (int a = i, b = j - 1; a < b; a++, b--) begin
                        t = trial[a];
                        trial[a] = trial[b];
                        trial[b] = t;
                    end
                    len = route_len(trial, n);
                    if (len < cur) begin
                        path = trial;
                        cur = len;
                        better = 1;
                    end
                end
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        path_word_t w, got;
        if (!rst_n) begin
            path_q.delete();
            held = 0;
            entry_x = 0;
            entry_y = 0;
            exit_x = 0;
            exit_y = 0;
            fails = 0;
            pending = 0;
            words_checked = 0;
        end else begin
            if (cfg_we) begin
                case (scord_pkg::reg_index_t'(cfg_index))
                    scord_pkg::REG_START_X: entry_x = cfg_wdata;
                    scord_pkg::REG_START_Y: entry_y = cfg_wdata;
                    scord_pkg::REG_END_X:   exit_x = cfg_wdata;
                    scord_pkg::REG_END_Y:   exit_y = cfg_wdata;
                    default: ;
                endcase
            end
            if (start && !busy) begin
                // drop coordinates past capacity, the last mark still closes the set
                if (held < CAP) begin
                    x_mem[held] = biased(x_coord);
                    y_mem[held] = biased(y_coord);
                    held++;
                end
                if (last_cell) begin
                    order_cells(held);
                    for (int k = 0; k < held; k++) begin
                        w.idx = path[k][5:0];
                        w.last = (k + 1 == held);
                        path_q.insert(path_q.size(), w);
                    end
                    held = 0;
                end
            end
            if (result_valid) begin
                got.idx = cell_index;
                got.last = last_in_path;
                if (path_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected result word: index %0d last %0b",
                                 got.idx, got.last);
                end else begin
                    w = path_q.pop_front();
                    words_checked++;
                    if (got.idx !== w.idx || got.last !== w.last) begin
                        fails++;
                        if (fails <= 10)
                            $display("mismatch: expected index %0d last %0b, got %0d last %0b",
                                     w.idx, w.last, got.idx, got.last);
                    end
                end
            end
            pending = path_q.size();
        end
    end

endmodule

/* sim/testbench.sv */
// Stimulus and verdict for the scan chain ordering core.
// Depends on scord_pkg, scan_chain_order_nn_2opt_core and scord_checker.
`timescale 1ns / 1ps

module testbench;

    localparam int LIMIT = 6_000_000;
    localparam int MIN = 32'sh8000_0000;
    localparam int MAX = 32'sh7FFF_FFFF;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] x_coord, y_coord;
    logic               last_cell;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic signed [31:0] cfg_wdata;
    logic               result_valid;
    logic [5:0]         cell_index;
    logic               last_in_path;
    int                 fails, pending, words_checked;
    int                 cycles;
    int                 sets_sent;
    int                 cells_sent;

    scan_chain_order_nn_2opt_core uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .x_coord(x_coord), .y_coord(y_coord), .last_cell(last_cell),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .result_valid(result_valid), .cell_index(cell_index), .last_in_path(last_in_path)
    );

    scord_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .x_coord(x_coord), .y_coord(y_coord), .last_cell(last_cell),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .result_valid(result_valid), .cell_index(cell_index), .last_in_path(last_in_path),
        .fails(fails), .pending(pending), .words_checked(words_checked)
    );

    initial begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("testbench NOT OK");
            $finish;
        end
    end

    // hold the word until the core takes it; start stays high for a follow-on word
    task automatic send_cell(int x, int y, bit last);
        start <= 1;
        x_coord <= x;
        y_coord <= y;
        last_cell <= last;
        do
            @(posedge clk);
        while (busy);
        cells_sent++;
        if (last)
            sets_sent++;
    endtask

    task automatic pause(int n);
        start <= 0;
        repeat (n) @(posedge clk);
    endtask

    // wait out every expected word, then let the core settle
    task automatic drain();
        pause(1);
        @(posedge clk);
        while (pending != 0 || busy)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_points(int sx, int sy, int ex, int ey);
        int v[4];
        v = '{sx, sy, ex, ey};
        for (int i = 0; i < 4; i++) begin
            cfg_we <= 1;
            cfg_index <= i[1:0];
            cfg_wdata <= v[i];
            @(posedge clk);
        end
        cfg_we <= 0;
        @(posedge clk);
    endtask

    function automatic int pick_coord(int mode);
        case (mode)
            0: return $urandom_range(8) - 4;
            1: return $urandom_range(2000) - 1000;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int n, mode, items;
        cycles = 0;
        sets_sent = 0;
        cells_sent = 0;
        rst_n = 0;
        start = 0;
        x_coord = 0;
        y_coord = 0;
        last_cell = 0;
        cfg_we = 0;
        cfg_index = scord_pkg::REG_START_X;
        cfg_wdata = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // single cell and two cells at the coordinate extremes
        send_cell(MAX, MIN, 1);
        pause(3);
        send_cell(MIN, MAX, 0);
        send_cell(0, 0, 1);
        // equal distances from the entry point: lowest index first
        send_cell(1, 0, 0);
        send_cell(0, 1, 0);
        send_cell(-1, 0, 0);
        send_cell(0, -1, 1);
        drain();

        // greedy walk leaves a crossing for 2-opt to remove
        set_points(0, 0, 10, 0);
        send_cell(1, 0, 0);
        send_cell(2, 5, 0);
        send_cell(3, 0, 0);
        send_cell(2, -5, 0);
        send_cell(9, 0, 0);
        send_cell(-3, 1, 1);
        drain();

        set_points(MIN, MIN, MAX, MAX);
        send_cell(MAX, MAX, 0);
        send_cell(MIN, MIN, 0);
        send_cell(MIN, MAX, 1);
        drain();

        // full store plus two words past capacity, last mark on a dropped word
        set_points(0, 0, 70, 0);
        for (int k = 1; k <= 66; k++)
            send_cell(k, 0, k == 66);
        drain();

        set_points(MAX, MAX, MIN, MIN);
        items = 0;
        while (items < 100) begin
            if ($urandom_range(4) == 0) begin
                drain();
                case ($urandom_range(2))
                    0: set_points($urandom, $urandom, $urandom, $urandom);
                    1: set_points(pick_coord(0), pick_coord(0), pick_coord(1), pick_coord(1));
                    default: set_points(MIN, MAX, MAX, MIN);
                endcase
            end
            n = ($urandom_range(9) == 0) ? $urandom_range(16, 9) : $urandom_range(8, 1);
            mode = $urandom_range(2);
            for (int k = 0; k < n; k++) begin
                send_cell(pick_coord(mode), pick_coord(mode), k == n - 1);
                items++;
                if (items < 80 && $urandom_range(3) == 0)
                    pause($urandom_range(10, 1));
            end
        end
        drain();

        $display("ordered %0d cell sets from %0d loaded words, %0d path words checked",
                 sets_sent, cells_sent, words_checked);
        $display("covered ties, 2-opt fixes, capacity overflow and extreme entry/exit points");
        if (fails == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
